@@ hw/rtl/svre_pkg.sv @@
// ----------------------------------------------------------------------------
// svre_pkg
// Shared types and codes of the shortest-path vertex relax engine.
// ----------------------------------------------------------------------------
package svre_pkg;

    typedef logic [1:0] t_op;

    // Operation codes carried on the input channel.
    localparam t_op OP_INIT   = 2'd0;
    localparam t_op OP_GATHER = 2'd1;
    localparam t_op OP_REDUCE = 2'd2;
    localparam t_op OP_APPLY  = 2'd3;

    // Result kinds.
    localparam logic KIND_GATHER = 1'b0;
    localparam logic KIND_APPLY  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_VERTEX_BASE   = 1'b0;
    localparam logic CFG_SOURCE_VERTEX = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted transaction
        logic rd;     // read the vertex stores
        logic exec;   // update state and, where due, the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic res_possible;  // the held item may produce a result
        logic out_free;      // the result register can take a new result
    } t_sts;

endpackage

@@ hw/rtl/svre_ctrl.sv @@
// ----------------------------------------------------------------------------
// svre_ctrl
// Sequencer of the vertex relax engine: accept, read, execute.
// ----------------------------------------------------------------------------
module svre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  svre_pkg::t_sts i_sts,
    output svre_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.rd    = 1'b0;
        o_cmd.exec  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                // Hold the item while a result could not be stored.
                if (!i_sts.res_possible || i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/svre_datapath.sv @@
// ----------------------------------------------------------------------------
// svre_datapath
// Vertex stores, gather accumulator, configuration and result register.
// ----------------------------------------------------------------------------
module svre_datapath #(
    parameter int VERTEX_DEPTH  = 65536,
    parameter int DIST_INFINITY = 2147483647
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  svre_pkg::t_cmd i_cmd,
    output svre_pkg::t_sts o_sts,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_addr,
    input  logic [30:0]    i_cfg_wdata,
    input  logic [1:0]     i_op,
    input  logic [30:0]    i_vertex_id,
    input  logic [30:0]    i_neighbor_id,
    input  logic [30:0]    i_candidate_dist,
    input  logic           i_last,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_kind,
    output logic [30:0]    o_out_vertex,
    output logic [30:0]    o_dist_res,
    output logic           o_active
);

    localparam int          AW    = $clog2(VERTEX_DEPTH);
    localparam logic [30:0] DEPTH = 31'(VERTEX_DEPTH);
    localparam logic [30:0] INF   = 31'(DIST_INFINITY);

    logic [30:0] r_vertex_base;
    logic [30:0] r_source_vertex;

    logic [1:0]    r_op;
    logic [30:0]   r_vid;
    logic [30:0]   r_cand;
    logic          r_last;
    logic          r_local;
    logic [AW-1:0] r_idx;

    logic [30:0] dist_mem [VERTEX_DEPTH];
    logic [30:0] msg_mem  [VERTEX_DEPTH];
    logic        act_mem  [VERTEX_DEPTH];
    logic [30:0] r_dist_rd;
    logic [30:0] r_msg_rd;
    logic        r_act_rd;

    logic [30:0] r_gmin;
    logic        r_gimpr;
    logic [30:0] n_gmin;
    logic        n_gimpr;

    logic        r_out_valid;
    logic        r_kind;
    logic [30:0] r_out_vertex;
    logic [30:0] r_dist_res;
    logic        r_active;

    logic [30:0] tgt;
    logic [30:0] diff;
    logic        tgt_local;
    logic [30:0] init_val;
    logic [30:0] cand_sat;
    logic [30:0] nbr_dist;
    logic [30:0] nbr_cand;
    logic        apply_take;
    logic        dist_we;
    logic        msg_we;
    logic        act_we;
    logic [30:0] dist_wdata;
    logic [30:0] msg_wdata;
    logic        act_wdata;
    logic        res_load;
    logic        out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_base   <= '0;
            r_source_vertex <= 31'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                svre_pkg::CFG_VERTEX_BASE:   r_vertex_base   <= i_cfg_wdata;
                svre_pkg::CFG_SOURCE_VERTEX: r_source_vertex <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Gather looks up the neighbor; every other operation the target vertex.
    always_comb begin
        tgt       = (i_op == svre_pkg::OP_GATHER) ? i_neighbor_id : i_vertex_id;
        diff      = tgt - r_vertex_base;
        tgt_local = (tgt >= r_vertex_base) && (diff < DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_vid   <= i_vertex_id;
            r_cand  <= i_candidate_dist;
            r_last  <= i_last;
            r_local <= tgt_local;
            r_idx   <= diff[AW-1:0];
        end
    end

    always_comb begin
        init_val   = (r_vid == r_source_vertex) ? '0 : INF;
        cand_sat   = (r_cand >= INF) ? INF : r_cand;
        nbr_dist   = (r_dist_rd >= INF) ? INF : r_dist_rd;
        nbr_cand   = (nbr_dist >= INF) ? INF : nbr_dist + 31'd1;
        apply_take = (r_dist_rd > r_msg_rd);

        dist_we    = 1'b0;
        msg_we     = 1'b0;
        act_we     = 1'b0;
        dist_wdata = init_val;
        msg_wdata  = init_val;
        act_wdata  = 1'b1;
        n_gmin     = r_gmin;
        n_gimpr    = r_gimpr;
        res_load   = 1'b0;

        unique case (r_op)
            svre_pkg::OP_INIT: begin
                dist_we = r_local;
                msg_we  = r_local;
                act_we  = r_local;
            end
            svre_pkg::OP_GATHER: begin
                if (r_local && r_act_rd && (r_gmin > nbr_cand)) begin
                    n_gmin  = nbr_cand;
                    n_gimpr = 1'b1;
                end
                res_load = r_last && n_gimpr;
            end
            svre_pkg::OP_REDUCE: begin
                msg_we    = r_local && (r_msg_rd > cand_sat);
                msg_wdata = cand_sat;
            end
            svre_pkg::OP_APPLY: begin
                dist_we    = r_local && apply_take;
                dist_wdata = r_msg_rd;
                act_we     = r_local;
                act_wdata  = apply_take;
                res_load   = r_local;
            end
            default: ;
        endcase
    end

    // Vertex stores: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && dist_we) begin
            dist_mem[r_idx] <= dist_wdata;
        end
        if (i_cmd.rd) begin
            r_dist_rd <= dist_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && msg_we) begin
            msg_mem[r_idx] <= msg_wdata;
        end
        if (i_cmd.rd) begin
            r_msg_rd <= msg_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && act_we) begin
            act_mem[r_idx] <= act_wdata;
        end
        if (i_cmd.rd) begin
            r_act_rd <= act_mem[r_idx];
        end
    end

    // Gather accumulator; the last neighbor closes the run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gmin  <= INF;
            r_gimpr <= 1'b0;
        end else if (i_cmd.exec && (r_op == svre_pkg::OP_GATHER)) begin
            if (r_last) begin
                r_gmin  <= INF;
                r_gimpr <= 1'b0;
            end else begin
                r_gmin  <= n_gmin;
                r_gimpr <= n_gimpr;
            end
        end
    end

    // Result register.
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec && res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && res_load) begin
            r_out_vertex <= r_vid;
            if (r_op == svre_pkg::OP_GATHER) begin
                r_kind     <= svre_pkg::KIND_GATHER;
                r_dist_res <= n_gmin;
                r_active   <= 1'b1;
            end else begin
                r_kind     <= svre_pkg::KIND_APPLY;
                r_dist_res <= apply_take ? r_msg_rd : r_dist_rd;
                r_active   <= apply_take;
            end
        end
    end

    assign o_sts.res_possible = ((r_op == svre_pkg::OP_GATHER) && r_last)
                             || ((r_op == svre_pkg::OP_APPLY) && r_local);
    assign o_sts.out_free     = out_free;

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_vertex = r_out_vertex;
    assign o_dist_res   = r_dist_res;
    assign o_active     = r_active;

endmodule

@@ hw/rtl/sssp_vertex_relax_engine_unit.sv @@
// ----------------------------------------------------------------------------
// sssp_vertex_relax_engine_unit
// Sequence: a transaction is accepted, the vertex stores are read, and it is
// executed, loading the result register where due. The next transaction is
// accepted only after that execution, set by the single read-modify-write pass
// over the vertex stores; execution waits while a held result is stalled and
// the next one is due.
// Reset: synchronous, active low; clears control, configuration and the gather
// accumulator. The vertex stores are not cleared and hold nothing until init.
// ----------------------------------------------------------------------------
module sssp_vertex_relax_engine_unit #(
    parameter int VERTEX_DEPTH  = 65536,
    parameter int DIST_INFINITY = 2147483647
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [30:0] i_cfg_wdata,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [30:0] i_vertex_id,
    input  logic [30:0] i_neighbor_id,
    input  logic [30:0] i_candidate_dist,
    input  logic        i_last,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [30:0] o_out_vertex,
    output logic [30:0] o_dist_res,
    output logic        o_active
);

    // The controller walks each transaction through three steps. In the first
    // the datapath captures the fields and turns the addressed global id
    // (the neighbor for a gather, the target otherwise) into a local index and
    // a locality flag. In the second the distance, message and active stores
    // are read. In the third the operation updates the stores or the gather
    // accumulator and, where due, loads the result register.
    //
    // The result register decouples the two channels: new transactions are
    // accepted while a result waits. Only when the held transaction could
    // produce a result and the register is still occupied does execution wait.

    svre_pkg::t_cmd cmd;
    svre_pkg::t_sts sts;

    svre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    svre_datapath #(
        .VERTEX_DEPTH  (VERTEX_DEPTH),
        .DIST_INFINITY (DIST_INFINITY)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_op             (i_op),
        .i_vertex_id      (i_vertex_id),
        .i_neighbor_id    (i_neighbor_id),
        .i_candidate_dist (i_candidate_dist),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_out_vertex     (o_out_vertex),
        .o_dist_res       (o_dist_res),
        .o_active         (o_active)
    );

endmodule

@@ bench/tb_sssp_vertex_relax_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sssp_vertex_relax_engine_unit
// Self-checking bench for the unit-weight shortest-path vertex engine. A short
// table of hand-picked transactions comes first. Randomized Bellman-Ford rounds
// follow: init, gather runs, reduce and apply over a small window of vertices,
// mixed with noise. They run under several base/source settings. Each result is
// compared with the bench's behavioral engine copy or a typed row's own result.
// ----------------------------------------------------------------------------
module tb_sssp_vertex_relax_engine_unit;

    // ------------------------------------------------------------------------
    // Bench constants.
    // ------------------------------------------------------------------------
    localparam int          DEPTH        = 65536;
    localparam logic [30:0] DIST_INF     = 31'h7FFF_FFFF;
    localparam logic [30:0] ID_TOP       = 31'h7FFF_FFFF;
    // This margin covers any item still in flight that produces no result.
    localparam int          SETTLE       = 12;
    localparam int          LIMIT_CYCLES = 1_000_000;

    // One transaction on the input channel.
    typedef struct packed {
        svre_pkg::t_op op;
        logic [30:0]   vid;
        logic [30:0]   nid;
        logic [30:0]   cand;
        logic          last;
    } t_vx_item;

    // One transaction on the result channel.
    typedef struct packed {
        logic        kind;
        logic [30:0] vertex;
        logic [30:0] dist_val;
        logic        active;
    } t_vx_report;

    // A row of the directed table. Where typed is set, the row's own result
    // (kind follows from op, vertex from vid) replaces the computed one.
    typedef struct packed {
        svre_pkg::t_op op;
        logic [30:0]   vid;
        logic [30:0]   nid;
        logic [30:0]   cand;
        logic          last;
        logic          typed;
        logic          want_has;
        logic [30:0]   want_dist;
        logic          want_active;
    } t_dir_row;

    // Receiver stall behavior, picked anew at random intervals.
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BURSTY
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_wr_en      = 1'b0;
    logic        i_cfg_addr       = svre_pkg::CFG_VERTEX_BASE;
    logic [30:0] i_cfg_wdata      = '0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [1:0]  i_op             = svre_pkg::OP_INIT;
    logic [30:0] i_vertex_id      = '0;
    logic [30:0] i_neighbor_id    = '0;
    logic [30:0] i_candidate_dist = '0;
    logic        i_last           = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic        o_kind;
    logic [30:0] o_out_vertex;
    logic [30:0] o_dist_res;
    logic        o_active;

    sssp_vertex_relax_engine_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_vertex_id      (i_vertex_id),
        .i_neighbor_id    (i_neighbor_id),
        .i_candidate_dist (i_candidate_dist),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_out_vertex     (o_out_vertex),
        .o_dist_res       (o_dist_res),
        .o_active         (o_active)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the engine state. Store entries are indexed by local
    // index, just as in the block, so they survive a change of vertex_base.
    // ------------------------------------------------------------------------
    logic [30:0] dist_mem [DEPTH];
    logic [30:0] msg_mem  [DEPTH];
    logic        act_mem  [DEPTH];
    logic [30:0] acc_min      = DIST_INF;
    logic        acc_improved = 1'b0;
    logic [30:0] cfg_base     = '0;
    logic [30:0] cfg_source   = 31'd1;

    // Results computed at acceptance and not yet seen on the result channel.
    t_vx_report due_reports [$];

    // Bookkeeping.
    int unsigned cycle_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned settings     = 1;
    int          burst_left   = 0;
    int          win_lo       = 0;
    int          win_n        = 1;
    t_vx_report  head;
    t_rx_mode    rx_mode      = RX_FREE;
    int          rx_mode_left = 0;
    int          rx_hold_left = 0;
    logic        rx_hold      = 1'b0;

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Engine behavior.
    // ------------------------------------------------------------------------

    // A global id is local when it lies in [base, base + DEPTH).
    function automatic bit map_local(input logic [30:0] gid, output int unsigned idx);
        logic [31:0] offset;
        offset = {1'b0, gid} - {1'b0, cfg_base};
        idx    = offset;
        return (gid >= cfg_base) && (offset < DEPTH);
    endfunction

    // Applies one accepted transaction to the shadow state and says whether
    // it produces a result, and which.
    task automatic relax_vertex_op(input t_vx_item it, output bit has, output t_vx_report rep);
        int unsigned idx;
        int unsigned nidx;
        logic [30:0] d;
        logic [30:0] c;
        has = 1'b0;
        rep = '0;
        case (it.op)
            svre_pkg::OP_INIT: begin
                if (map_local(it.vid, idx)) begin
                    d = (it.vid == cfg_source) ? 31'd0 : DIST_INF;
                    dist_mem[idx] = d;
                    msg_mem[idx]  = d;
                    act_mem[idx]  = 1'b1;
                end
            end
            svre_pkg::OP_GATHER: begin
                // Only active local neighbors take part; a neighbor at
                // infinity stays at infinity instead of wrapping.
                if (map_local(it.nid, nidx) && act_mem[nidx]) begin
                    d = dist_mem[nidx];
                    c = (d == DIST_INF) ? DIST_INF : d + 31'd1;
                    if (acc_min > c) begin
                        acc_min      = c;
                        acc_improved = 1'b1;
                    end
                end
                // The target vertex is reported as given, local or not.
                if (it.last) begin
                    if (acc_improved) begin
                        has = 1'b1;
                        rep = '{svre_pkg::KIND_GATHER, it.vid, acc_min, 1'b1};
                    end
                    acc_min      = DIST_INF;
                    acc_improved = 1'b0;
                end
            end
            svre_pkg::OP_REDUCE: begin
                if (map_local(it.vid, idx) && msg_mem[idx] > it.cand) begin
                    msg_mem[idx] = it.cand;
                end
            end
            default: begin
                if (map_local(it.vid, idx)) begin
                    if (dist_mem[idx] <= msg_mem[idx]) begin
                        act_mem[idx] = 1'b0;
                    end else begin
                        dist_mem[idx] = msg_mem[idx];
                        act_mem[idx]  = 1'b1;
                    end
                    has = 1'b1;
                    rep = '{svre_pkg::KIND_APPLY, it.vid, dist_mem[idx], act_mem[idx]};
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Random values.
    // ------------------------------------------------------------------------

    // Global id of window vertex k under the current base.
    function automatic logic [30:0] win_id(input int k);
        return cfg_base + 31'(win_lo + k);
    endfunction

    // A non-local id: often fully random, sometimes just outside the range.
    function automatic logic [30:0] far_id();
        logic [30:0] gid;
        int unsigned idx;
        int          pick;
        pick = $urandom_range(0, 3);
        gid  = 31'($urandom);
        if (pick == 0 && cfg_base != 0) begin
            gid = cfg_base - 31'd1;
        end else if (pick == 1) begin
            gid = cfg_base + 31'(DEPTH);
        end
        while (map_local(gid, idx)) begin
            gid = 31'($urandom);
        end
        return gid;
    endfunction

    // Distances: infinity, small values that actually compete, or anything.
    function automatic logic [30:0] rand_dist();
        case ($urandom_range(0, 3))
            0: return DIST_INF;
            1: return 31'($urandom_range(0, 24));
            default: return 31'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Bursts of random length with random gaps in between; about four bursts
    // in ten follow the previous one with no gap at all.
    task automatic pace();
        int gap;
        int pick;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            pick       = $urandom_range(0, 9);
            if (pick < 4) begin
                gap = 0;
            end else if (pick < 9) begin
                gap = $urandom_range(1, 5);
            end else begin
                gap = $urandom_range(6, 20);
            end
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Presents one transaction, holds it until accepted, then records what
    // it should produce. A typed row supplies its own expected result.
    task automatic send_item(input t_vx_item it, input bit typed, input bit want_has,
                             input t_vx_report want, output bit has, output t_vx_report rep);
        pace();
        i_valid          <= 1'b1;
        i_op             <= it.op;
        i_vertex_id      <= it.vid;
        i_neighbor_id    <= it.nid;
        i_candidate_dist <= it.cand;
        i_last           <= it.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        relax_vertex_op(it, has, rep);
        if (typed) begin
            has = want_has;
            rep = want;
        end
        if (has) begin
            due_reports = {due_reports, rep};
        end
        items_sent++;
    endtask

    // Stops sending until every due result has arrived and anything still
    // in flight has had time to finish.
    task automatic drain();
        i_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back cycles; only call while idle.
    task automatic load_config(input logic [30:0] base, input logic [30:0] source);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= svre_pkg::CFG_VERTEX_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_addr  <= svre_pkg::CFG_SOURCE_VERTEX;
        i_cfg_wdata <= source;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_base   = base;
        cfg_source = source;
        settings++;
        @(posedge i_clk);
    endtask

    // Any operation on a window vertex or a far id, with gather runs cut at
    // random points.
    task automatic send_noise();
        t_vx_item   it;
        bit         has;
        t_vx_report rep;
        it.op   = svre_pkg::t_op'($urandom_range(0, 3));
        it.vid  = ($urandom_range(0, 3) == 0) ? far_id() : win_id($urandom_range(0, win_n - 1));
        it.nid  = ($urandom_range(0, 1) == 0) ? far_id() : win_id($urandom_range(0, win_n - 1));
        it.cand = rand_dist();
        it.last = 1'($urandom);
        send_item(it, 1'b0, 1'b0, '0, has, rep);
    endtask

    // One register setting: seed the window, then run relaxation rounds
    // until the budget of transactions is used up. Only seeded window entries
    // and non-local ids are ever read.
    task automatic run_phase(input logic [30:0] base, input logic [30:0] source,
                             input int lo, input int n, input int budget);
        int unsigned first;
        int          runs;
        t_vx_item    it;
        bit          has;
        t_vx_report  rep;
        drain();
        load_config(base, source);
        win_lo = lo;
        win_n  = n;
        first  = items_sent;
        for (int k = 0; k < n; k++) begin
            it = '{svre_pkg::OP_INIT, win_id(k), far_id(), rand_dist(), 1'($urandom)};
            send_item(it, 1'b0, 1'b0, '0, has, rep);
        end
        while (items_sent - first < budget) begin
            // Gather each vertex from a few in-neighbors, then hand the
            // candidate back to it as a message.
            for (int k = 0; k < n; k++) begin
                runs = $urandom_range(1, 4);
                for (int j = 0; j < runs; j++) begin
                    it.op   = svre_pkg::OP_GATHER;
                    it.vid  = ($urandom_range(0, 15) == 0) ? far_id() : win_id(k);
                    it.nid  = ($urandom_range(0, 9) < 8) ? win_id($urandom_range(0, n - 1))
                                                         : far_id();
                    it.cand = rand_dist();
                    it.last = (j == runs - 1);
                    send_item(it, 1'b0, 1'b0, '0, has, rep);
                end
                if (has && $urandom_range(0, 4) != 0) begin
                    it = '{svre_pkg::OP_REDUCE, win_id(k), far_id(), rep.dist_val,
                           1'($urandom)};
                    send_item(it, 1'b0, 1'b0, '0, has, rep);
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end
            end
            // A few stray messages, then commit every vertex.
            repeat ($urandom_range(0, 3)) begin
                it = '{svre_pkg::OP_REDUCE, win_id($urandom_range(0, n - 1)), far_id(),
                       rand_dist(), 1'($urandom)};
                send_item(it, 1'b0, 1'b0, '0, has, rep);
            end
            for (int k = 0; k < n; k++) begin
                it = '{svre_pkg::OP_APPLY, win_id(k), far_id(), rand_dist(), 1'($urandom)};
                send_item(it, 1'b0, 1'b0, '0, has, rep);
            end
            // Now and then restart a vertex, or let the pipeline run dry.
            if ($urandom_range(0, 5) == 0) begin
                it = '{svre_pkg::OP_INIT, win_id($urandom_range(0, n - 1)), far_id(),
                       rand_dist(), 1'($urandom)};
                send_item(it, 1'b0, 1'b0, '0, has, rep);
            end
            if ($urandom_range(0, 7) == 0) begin
                drain();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: stall pattern and result checking.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(64, 512);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                // Alternating stretches of random length, stalled and free.
                if (rx_hold_left == 0) begin
                    rx_hold_left = $urandom_range(1, 30);
                    rx_hold      = ~rx_hold;
                end else begin
                    rx_hold_left--;
                end
                i_stall <= rx_hold;
            end
        endcase
    end

    task automatic check_field(input string name, input logic [30:0] want, input logic [30:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (due_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d/%h/%h/%0d",
                         $time, o_kind, o_out_vertex, o_dist_res, o_active);
            end else begin
                head = due_reports.pop_front();
                check_field("kind", 31'(head.kind), 31'(o_kind));
                check_field("out_vertex", head.vertex, o_out_vertex);
                check_field("dist_res", head.dist_val, o_dist_res);
                check_field("active", 31'(head.active), 31'(o_active));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table, run under the reset settings (base 0, source 1).
    // ------------------------------------------------------------------------
    localparam bit T = 1'b1;
    localparam bit U = 1'b0;

    t_dir_row directed [27] = '{
        // Seed the source, both ends of the local range, and one id past it.
        '{svre_pkg::OP_INIT,   31'd1,     31'd0,     31'd0,    1'b0, T, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_INIT,   31'd0,     ID_TOP,    DIST_INF, 1'b1, T, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_INIT,   31'd2,     31'd7,     31'd3,    1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_INIT,   31'd65535, ID_TOP,    DIST_INF, 1'b1, T, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_INIT,   31'd65536, 31'd1,     31'd0,    1'b0, T, 1'b0, 31'd0,    1'b0},
        // Two-neighbor run: the source gives 1, an infinite neighbor nothing.
        '{svre_pkg::OP_GATHER, 31'd2,     31'd1,     31'd9,    1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_GATHER, 31'd2,     31'd0,     31'd0,    1'b1, T, 1'b1, 31'd1,    1'b1},
        // Non-local neighbor only: no improvement, no result.
        '{svre_pkg::OP_GATHER, ID_TOP,    31'd65536, 31'd0,    1'b1, T, 1'b0, 31'd0,    1'b0},
        // Non-local target is still reported.
        '{svre_pkg::OP_GATHER, ID_TOP,    31'd1,     DIST_INF, 1'b1, T, 1'b1, 31'd1,    1'b1},
        // Messages: infinity, a better value, a worse value.
        '{svre_pkg::OP_REDUCE, 31'd2,     31'd0,     DIST_INF, 1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_REDUCE, 31'd2,     31'd0,     31'd5,    1'b1, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_REDUCE, 31'd2,     31'd0,     31'd7,    1'b0, U, 1'b0, 31'd0,    1'b0},
        // Apply takes the message, then finds nothing new and deactivates.
        '{svre_pkg::OP_APPLY,  31'd2,     31'd0,     31'd0,    1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_APPLY,  31'd2,     31'd0,     31'd0,    1'b1, U, 1'b0, 31'd0,    1'b0},
        // Inactive neighbor is ignored.
        '{svre_pkg::OP_GATHER, 31'd9,     31'd2,     31'd0,    1'b1, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_APPLY,  31'd1,     31'd0,     31'd0,    1'b0, T, 1'b1, 31'd0,    1'b0},
        '{svre_pkg::OP_GATHER, 31'd100,   31'd1,     31'd0,    1'b1, U, 1'b0, 31'd0,    1'b0},
        // Top local vertex gets a zero message and becomes a second root.
        '{svre_pkg::OP_REDUCE, 31'd65535, 31'd0,     31'd0,    1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_APPLY,  31'd65535, 31'd0,     31'd0,    1'b0, T, 1'b1, 31'd0,    1'b1},
        // Mixed run: active, non-local and inactive neighbors.
        '{svre_pkg::OP_GATHER, 31'd0,     31'd65535, 31'd0,    1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_GATHER, 31'd0,     ID_TOP,    31'd0,    1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_GATHER, 31'd0,     31'd2,     31'd0,    1'b1, U, 1'b0, 31'd0,    1'b0},
        // Non-local apply and reduce do nothing.
        '{svre_pkg::OP_APPLY,  ID_TOP,    31'd0,     31'd0,    1'b0, T, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_REDUCE, ID_TOP,    31'd0,     31'd0,    1'b0, U, 1'b0, 31'd0,    1'b0},
        // An active neighbor at infinity must not wrap to zero.
        '{svre_pkg::OP_INIT,   31'd3,     31'd0,     31'd0,    1'b0, U, 1'b0, 31'd0,    1'b0},
        '{svre_pkg::OP_GATHER, 31'd4,     31'd3,     31'd0,    1'b1, U, 1'b0, 31'd0,    1'b0},
        // Non-source vertex after init stays infinite and goes inactive.
        '{svre_pkg::OP_APPLY,  31'd0,     31'd0,     31'd0,    1'b0, T, 1'b1, DIST_INF, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row    row;
        t_vx_item    it;
        t_vx_report  want;
        t_vx_report  rep;
        bit          has;
        logic [30:0] base;
        int          lo;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            row  = directed[r];
            it   = '{row.op, row.vid, row.nid, row.cand, row.last};
            want = '{(row.op == svre_pkg::OP_GATHER) ? svre_pkg::KIND_GATHER
                                                     : svre_pkg::KIND_APPLY,
                     row.vid, row.want_dist, row.want_active};
            send_item(it, row.typed, row.want_has, want, has, rep);
        end

        // Base at zero with the source at id zero.
        run_phase(31'd0, 31'd0, 0, 8, 350);
        // Window at the very top of the id space; source is the top id.
        run_phase(31'h7FFF_0000, ID_TOP, DEPTH - 8, 8, 350);
        // Highest base: a single local vertex, which is also the source.
        run_phase(ID_TOP, ID_TOP, 0, 1, 200);
        // Random base, source somewhere in the window.
        base = 31'($urandom_range(1, 32'h7FFE_0000));
        lo   = $urandom_range(0, DEPTH - 16);
        run_phase(base, base + 31'(lo + $urandom_range(0, 15)), lo, 16, 400);
        // Random base with a random source, normally outside the window.
        base = 31'($urandom_range(1, 32'h7FFE_0000));
        run_phase(base, 31'($urandom), $urandom_range(0, DEPTH - 6), 6, 250);
        // Back to the reset settings.
        run_phase(31'd0, 31'd1, 0, 12, 200);

        drain();

        $display("Sent %0d transactions under %0d register settings; %0d results checked.",
                 items_sent, settings, results_seen);
        $display("Covered init, gather runs, reduce and apply, including out-of-range ids.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/svre_pkg.sv
hw/rtl/svre_ctrl.sv
hw/rtl/svre_datapath.sv
hw/rtl/sssp_vertex_relax_engine_unit.sv
bench/tb_sssp_vertex_relax_engine_unit.sv
